[sv/hmm_forward_pairwise_filter_assert.svh]
// Assertion macros for the HMM forward filter.
`ifndef HMM_FORWARD_PAIRWISE_FILTER_ASSERT_SVH
`define HMM_FORWARD_PAIRWISE_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while rst is high.
`define HFPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst is high.
`define HFPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hfpf_pkg.sv]
// Shared types, widths and codes of the HMM forward filter.
`timescale 1ns / 1ps
package hfpf_pkg;
  localparam int PROB_W = 16;
  localparam int PROD_W = 48;
  localparam int SUM_W  = 54;
  localparam int QUO_W  = 17;
  localparam int ACC_W  = 19;
  localparam int MUL_A_W = 32;

  typedef logic [PROB_W-1:0] prob_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [QUO_W-1:0]  quo_t;

  localparam logic [2:0] ACT_LOAD_PRIOR = 3'd0;
  localparam logic [2:0] ACT_LOAD_TRANS = 3'd1;
  localparam logic [2:0] ACT_LOAD_EMIS  = 3'd2;
  localparam logic [2:0] ACT_OBS_FIRST  = 3'd3;
  localparam logic [2:0] ACT_OBS_NEXT   = 3'd4;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

[sv/hmm_forward_pairwise_filter.sv]
// Top level of the HMM forward filter: tables, sequencer and result stage.
// A load is written as it is accepted. An observation passes each joint entry through a
// table read and the shared multiplier (a second product after the first observation) and an
// accumulate, then per result: a joint read, a divider load, 17 divider steps, registering
// the quotient and the handshake, plus any stall. One request at a time.
// Reset (rst, synchronous) clears the marginal, sets k to 8 and empties the output.
`timescale 1ns / 1ps
`include "hmm_forward_pairwise_filter_assert.svh"
module hmm_forward_pairwise_filter
  import hfpf_pkg::*;
#(
  parameter int MAX_STATES  = 8,
  parameter int NUM_SYMBOLS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row_index[2:0], col_index[6:3], load_value[22:7], symbol[26:23], zero pad
  input  logic [31:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // from_state[2:0], to_state[5:3], joint_prob[21:6], zero pad
  output logic [23:0] m_axis_tdata,
  // zero_sum
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  localparam int SW = $clog2(MAX_STATES);
  localparam int YW = $clog2(NUM_SYMBOLS);
  localparam int SDEPTH = 2 ** SW;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_MA   = 4'd2;
  localparam logic [3:0] ST_MB   = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_JRD  = 4'd5;
  localparam logic [3:0] ST_DST  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  // Request fields.
  logic [2:0]  in_action;
  logic [2:0]  in_row;
  logic [3:0]  in_col;
  prob_t       in_value;
  logic [3:0]  in_symbol;
  logic        in_accept;

  assign in_row    = s_axis_tdata[2:0];
  assign in_col    = s_axis_tdata[6:3];
  assign in_value  = s_axis_tdata[22:7];
  assign in_symbol = s_axis_tdata[26:23];
  assign in_action = s_axis_tuser;

  logic [3:0]    state;
  logic [3:0]    k_cfg;
  logic [3:0]    k_m1;
  logic          first;
  logic [YW-1:0] sym;
  logic [SW-1:0] r;
  logic [SW-1:0] s;
  logic          r_end;
  logic          run_end;
  sum_t          sum;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;

  // Tables. The prior and marginal live in flops; the rest are memories.
  prob_t prior_table [SDEPTH];
  prob_t marginal    [SDEPTH];
  prob_t trans_mem   [SDEPTH*SDEPTH];
  prob_t emis_mem    [SDEPTH*(2**YW)];
  prod_t joint_mem   [SDEPTH*SDEPTH];
  prob_t trans_rd;
  prob_t emis_rd;
  prob_t pm_rd;
  prod_t joint_rd;

  // Result stage.
  logic [SW-1:0] out_from;
  logic [SW-1:0] out_to;
  prob_t         out_q;
  logic          out_zero;
  logic          out_last;

  // Shared units.
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  prob_t              mul_b;
  prod_t              mul_p;
  div_ctl_t           div_ctl;
  quo_t               div_quot;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = state == ST_IDLE;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // k is clamped to the supported range.
  always_comb begin
    if (k_cfg < 4'd2) begin
      k_m1 = 4'd1;
    end else if (32'(k_cfg) > MAX_STATES) begin
      k_m1 = 4'(MAX_STATES - 1);
    end else begin
      k_m1 = k_cfg - 4'd1;
    end
  end

  assign r_end   = 4'(r) == k_m1;
  assign run_end = r_end && (4'(s) == k_m1);
  assign acc_next = acc + ACC_W'(out_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_cfg <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      k_cfg <= cfg_data;
    end
  end

  // Load writes happen while the sequencer idles.
  always_ff @(posedge clk) begin
    if (in_accept && in_action == ACT_LOAD_PRIOR && 32'(in_row) < MAX_STATES) begin
      prior_table[in_row[SW-1:0]] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_action == ACT_LOAD_TRANS && 32'(in_row) < MAX_STATES &&
        32'(in_col) < MAX_STATES) begin
      trans_mem[{in_row[SW-1:0], in_col[SW-1:0]}] <= in_value;
    end
    trans_rd <= trans_mem[{r, s}];
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_action == ACT_LOAD_EMIS && 32'(in_row) < MAX_STATES &&
        32'(in_col) < NUM_SYMBOLS) begin
      emis_mem[{in_row[SW-1:0], in_col[YW-1:0]}] <= in_value;
    end
    emis_rd <= emis_mem[{s, sym}];
  end

  always_ff @(posedge clk) begin
    if (state == ST_ACC) begin
      joint_mem[{s, r}] <= mul_p;
    end
    joint_rd <= joint_mem[{s, r}];
  end

  always_ff @(posedge clk) begin
    pm_rd <= first ? prior_table[r] : marginal[r];
  end

  // First step multiplies prior by emission; later steps chain two products.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = MUL_A_W'(pm_rd);
    mul_b  = first ? emis_rd : trans_rd;
    if (state == ST_MA) begin
      mul_en = 1'b1;
    end else if (state == ST_MB) begin
      mul_en = 1'b1;
      mul_a  = mul_p[MUL_A_W-1:0];
      mul_b  = emis_rd;
    end
  end

  hfpf_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign div_ctl.start = state == ST_DST;

  hfpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctl.start),
    .dividend (joint_rd),
    .divisor  (sum),
    .busy     (div_ctl.busy),
    .quot     (div_quot)
  );

  // Main sequencer: products and sum first, then one division per result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < SDEPTH; i++) begin
        marginal[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept && (in_action == ACT_OBS_FIRST || in_action == ACT_OBS_NEXT) &&
              32'(in_symbol) < NUM_SYMBOLS) begin
            first <= in_action == ACT_OBS_FIRST;
            sym   <= in_symbol[YW-1:0];
            r     <= '0;
            s     <= '0;
            sum   <= '0;
            acc   <= '0;
            state <= ST_RD;
          end
        end
        ST_RD: state <= ST_MA;
        ST_MA: state <= first ? ST_ACC : ST_MB;
        ST_MB: state <= ST_ACC;
        ST_ACC: begin
          sum <= sum + SUM_W'(mul_p);
          if (run_end) begin
            r     <= '0;
            s     <= '0;
            state <= ST_JRD;
          end else begin
            if (r_end) begin
              r <= '0;
              s <= s + 1'b1;
            end else begin
              r <= r + 1'b1;
            end
            state <= ST_RD;
          end
        end
        ST_JRD: state <= ST_DST;
        ST_DST: state <= ST_DIV;
        ST_DIV: begin
          if (!div_ctl.busy) begin
            out_from      <= r;
            out_to        <= s;
            out_zero      <= sum == '0;
            out_last      <= run_end;
            if (sum == '0) begin
              out_q <= '0;
            end else if (div_quot[QUO_W-1]) begin
              out_q <= '1;
            end else begin
              out_q <= div_quot[PROB_W-1:0];
            end
            m_axis_tvalid <= 1'b1;
            state         <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (r_end) begin
              marginal[s] <= (acc_next > ACC_W'(16'hFFFF)) ? '1 : acc_next[PROB_W-1:0];
              acc         <= '0;
            end else begin
              acc <= acc_next;
            end
            if (run_end) begin
              state <= ST_IDLE;
            end else begin
              if (r_end) begin
                r <= '0;
                s <= s + 1'b1;
              end else begin
                r <= r + 1'b1;
              end
              state <= ST_JRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, out_q, 3'(out_to), 3'(out_from)};
  assign m_axis_tuser = out_zero;
  assign m_axis_tlast = out_last;

  // The block never takes a request while a result is pending.
  `HFPF_ASSERT_NOW(a_idle_no_result, s_axis_tready, !m_axis_tvalid, "request taken mid-run")
  // The final result of a run returns the block to idle.
  `HFPF_ASSERT_NEXT(a_last_to_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast,
    s_axis_tready, "block not idle after final result")
  // A zero sum always yields a zero probability.
  `HFPF_ASSERT_NOW(a_zero_sum_value, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata[21:6] == 16'd0, "nonzero value with zero sum")
endmodule

[sv/hfpf_mul.sv]
// Shared registered multiplier of the HMM forward filter.
`timescale 1ns / 1ps
module hfpf_mul
  import hfpf_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  prob_t              b,
  output prod_t              p
);
  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b);
    end
  end
endmodule

[sv/hfpf_div.sv]
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module hfpf_div
  import hfpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  prod_t dividend,
  input  sum_t  divisor,
  output logic  busy,
  output quo_t  quot
);
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [SUM_W:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic             ge;
  logic [SUM_W:0]   diff;
  logic [SUM_W:0]   sel;

  assign ge   = rem >= (SUM_W+1)'(divisor);
  assign diff = rem - (SUM_W+1)'(divisor);
  assign sel  = ge ? diff : rem;
  assign busy = cnt != '0;

  // The remainder stays below the divisor after every step, so the shift fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= (SUM_W+1)'(dividend);
      quot <= '0;
    end else if (busy) begin
      rem  <= {sel[SUM_W-1:0], 1'b0};
      quot <= {quot[QUO_W-2:0], ge};
    end
  end
endmodule
